/* hw/rtl/tfcl_pkg.sv */
// tfcl_pkg: shared types and constants for the transfer function colour lookup unit
// no dependencies; used by tfcl_div and transfer_function_color_lookup_unit
package tfcl_pkg;

	localparam int CH_BITS    = 16;
	localparam int CNT_W      = 5;
	localparam int FRAC_Q412  = 12;
	localparam int DIV_LANES  = 3;
	localparam int DIV_NUM_W  = 32;
	localparam int DIV_DEN_W  = 16;
	localparam int DIV_STEPS  = 16;
	localparam int SQRT_STEPS = 17;

	localparam logic [CH_BITS:0]   CH_ONE   = 17'h10000;
	localparam logic [CH_BITS-1:0] CH_MAX   = 16'hFFFF;
	localparam logic [15:0]        AF_RESET = 16'd4096;

	typedef enum logic [1:0] {
		OP_QUERY = 2'd0,
		OP_DENS  = 2'd1,
		OP_GRAD  = 2'd2,
		OP_RAD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_DENS_CNT = 2'd0,
		REG_GRAD_CNT = 2'd1,
		REG_RAD_CNT  = 2'd2,
		REG_ALPHA_F  = 2'd3
	} reg_idx_t;

	// index 0 red, 1 green, 2 blue, 3 alpha
	typedef logic [3:0][CH_BITS-1:0] col_t;

	typedef struct packed {
		logic [CH_BITS-1:0] key;
		col_t               col;
	} lin_pt_t;

	typedef struct packed {
		logic [CH_BITS-1:0] x;
		logic [CH_BITS-1:0] y;
		logic [15:0]        rad;
		col_t               col;
	} rad_pt_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

	typedef enum logic [1:0] {
		PH_DENS,
		PH_GRAD,
		PH_RPT,
		PH_RFIN
	} ph_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LK_START,
		ST_LK_SCAN,
		ST_LK_SCANEND,
		ST_LK_RD0,
		ST_LK_RD1,
		ST_LK_RD2,
		ST_LK_AMT,
		ST_LK_DIV,
		ST_LK_MUL,
		ST_OV_MUL,
		ST_OV_DIV,
		ST_OV_WAIT,
		ST_RP_START,
		ST_RP_RD,
		ST_RP_LD,
		ST_RP_SQ,
		ST_RP_SQRT,
		ST_RP_RATIO,
		ST_RP_DIV,
		ST_RP_FADE,
		ST_AF,
		ST_OUT
	} st_t;

endpackage

/* hw/rtl/tfcl_div.sv */
// tfcl_div: three-lane restoring divider, 32-bit by 16-bit, 16 quotient bits
// one quotient bit per cycle; the caller keeps numerator high half below the divisor
// depends on tfcl_pkg
module tfcl_div (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  tfcl_pkg::div_req_t                                     req,
	input  logic [tfcl_pkg::DIV_LANES-1:0][tfcl_pkg::DIV_NUM_W-1:0] num,
	output tfcl_pkg::div_rsp_t                                     rsp,
	output logic [tfcl_pkg::DIV_LANES-1:0][tfcl_pkg::DIV_DEN_W-1:0] quo
);
	import tfcl_pkg::*;

	logic                                  busy_q;
	logic                                  done_q;
	logic [4:0]                            cnt_q;
	logic [DIV_DEN_W-1:0]                  den_q;
	logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   rem_q;
	logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   nlo_q;
	logic [DIV_LANES-1:0][DIV_DEN_W:0]     rem_sh;
	logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   rem_nx;
	logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   nlo_nx;
	logic [DIV_LANES-1:0]                  fits;

	always_comb begin
		for (int l = 0; l < DIV_LANES; l++) begin
			rem_sh[l] = {rem_q[l], nlo_q[l][DIV_DEN_W-1]};
			fits[l]   = rem_sh[l] >= {1'b0, den_q};
			rem_nx[l] = fits[l] ? DIV_DEN_W'(rem_sh[l] - {1'b0, den_q})
			                    : rem_sh[l][DIV_DEN_W-1:0];
			nlo_nx[l] = {nlo_q[l][DIV_DEN_W-2:0], fits[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			for (int l = 0; l < DIV_LANES; l++) begin
				rem_q[l] <= num[l][DIV_NUM_W-1:DIV_DEN_W];
				nlo_q[l] <= num[l][DIV_DEN_W-1:0];
			end
		end else if (busy_q) begin
			rem_q <= rem_nx;
			nlo_q <= nlo_nx;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quo      = nlo_q;

endmodule

/* hw/rtl/transfer_function_color_lookup_unit.sv */
// transfer_function_color_lookup_unit: 2d transfer function colour lookup, top level
// three point memories, sequencer, shared multiplier, square root and tfcl_div
// depends on tfcl_pkg and tfcl_div
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | op slot pos_x pos_y in_red in_green in_blue
//          |                      | in_alpha radius use_alpha_factor
//  out     | out_valid / out_ready| out_red out_green out_blue out_alpha
//  cfg     | cfg_valid / cfg_ready| cfg_index cfg_data
//
// a point write gives no result
// a query's running time grows with the points in use of each list and is set by
// the 16-step divider, the 17-step square root and the registered shared multiplier
// one item is worked on at a time; a query waits at its end while the output register is full
// reset clears counts, sets the alpha factor to one; point memories hold garbage until written
module transfer_function_color_lookup_unit #(
	parameter int MAX_POINTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  slot,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] in_red,
	input  logic [15:0] in_green,
	input  logic [15:0] in_blue,
	input  logic [15:0] in_alpha,
	input  logic [15:0] radius,
	input  logic        use_alpha_factor,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue,
	output logic [15:0] out_alpha,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tfcl_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NW = $clog2(MAX_POINTS + 1);

	// point memories
	lin_pt_t dmem [MAX_POINTS];
	lin_pt_t gmem [MAX_POINTS];
	rad_pt_t rmem [MAX_POINTS];
	lin_pt_t dens_rd_q;
	lin_pt_t grad_rd_q;
	rad_pt_t rad_rd_q;
	logic [AW-1:0] rd_addr;

	// configuration
	logic [CNT_W-1:0] dens_cnt_q, grad_cnt_q, rad_cnt_q;
	logic [15:0]      af_q;

	// control
	st_t  state_q, state_nxt;
	ph_t  phase_q;
	logic [2:0]    step_q;
	logic          mph_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] idx_q;
	logic [NW-1:0] j_q;
	logic          lk_sel_q;
	logic          ov_acc_q;
	logic          scan_vld_s1;
	logic [AW-1:0] scan_idx_s1;
	logic          out_valid_q;

	// datapath
	logic [15:0]        qx_q, qy_q;
	logic               uaf_q;
	col_t               col_q, acc_q, src_q, lka_q, lkb_q, out_q;
	logic [15:0]        kl_q, kr_q;
	logic [16:0]        amt_q;
	logic [15:0]        t_q;
	logic [16:0]        al_q;
	logic [DIV_LANES-1:0][DIV_NUM_W-1:0] numacc_q;
	logic [32:0]        sum_q;
	logic [33:0]        prod_q;
	logic [15:0]        dx_q, dy_q, rad_q;
	logic [32:0]        sq_q;
	logic [33:0]        sqv_q;
	logic [16:0]        root_q;
	logic [18:0]        srem_q;
	logic [4:0]         scnt_q;
	logic [16:0]        ratio_q;

	// combinational helpers
	logic               in_acc, slot_ok, out_ok, mul_st, ov_fin;
	logic [NW-1:0]      dn, gn, rn, lk_n;
	logic [AW-1:0]      lk_last;
	lin_pt_t            rd_lin;
	logic [15:0]        lk_q;
	logic signed [16:0] lk_num, lk_den;
	logic [15:0]        lk_un, lk_ud;
	logic               lk_ok, lk_sat, lk_go;
	logic               rp_sat;
	col_t               ovb;
	col_t               ov_res;
	logic [1:0]         ov_ch;
	logic [32:0]        lk_sum;
	logic [19:0]        af_prod;
	logic [20:0]        sq_rem_sh, sq_trial;
	logic               sq_fit;
	logic [16:0]        mul_x, mul_y;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic [DIV_LANES-1:0][DIV_NUM_W-1:0] div_num;
	logic [DIV_LANES-1:0][DIV_DEN_W-1:0] div_quo;

	tfcl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.rsp    (div_rsp),
		.quo    (div_quo)
	);

	assign in_acc  = in_valid && in_ready;
	assign slot_ok = 32'(slot) < MAX_POINTS;
	assign out_ok  = !out_valid_q || out_ready;

	always_comb begin
		dn = (32'(dens_cnt_q) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(dens_cnt_q);
		gn = (32'(grad_cnt_q) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(grad_cnt_q);
		rn = (32'(rad_cnt_q) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(rad_cnt_q);
		lk_n    = lk_sel_q ? gn : dn;
		lk_last = AW'(lk_n - NW'(2));
		rd_lin  = lk_sel_q ? grad_rd_q : dens_rd_q;
		lk_q    = lk_sel_q ? qy_q : qx_q;

		lk_num = $signed({1'b0, lk_q}) - $signed({1'b0, kl_q});
		lk_den = $signed({1'b0, kr_q}) - $signed({1'b0, kl_q});
		lk_un  = lk_num[16] ? 16'(-lk_num) : lk_num[15:0];
		lk_ud  = lk_den[16] ? 16'(-lk_den) : lk_den[15:0];
		lk_ok  = (lk_num != '0) && (lk_den != '0) && (lk_num[16] == lk_den[16]);
		lk_sat = lk_ok && (lk_un >= lk_ud);
		lk_go  = lk_ok && (lk_un < lk_ud);

		// distance at or beyond sixteen radii means the ratio saturates
		rp_sat = (rad_q == '0) || ({3'b0, root_q} >= {rad_q, 4'b0});

		ovb    = ov_acc_q ? acc_q : col_q;
		ov_ch  = 2'((step_q - 3'd1) >> 1);
		ov_res = (al_q == '0) ? col_t'('0)
		       : {((al_q > {1'b0, CH_MAX}) ? CH_MAX : al_q[15:0]),
		          div_quo[2], div_quo[1], div_quo[0]};
		ov_fin = ((state_q == ST_OV_DIV) && (al_q == '0)) ||
		         ((state_q == ST_OV_WAIT) && div_rsp.done);

		lk_sum  = sum_q + prod_q[32:0];
		af_prod = prod_q[31:12];

		sq_rem_sh = {srem_q, sqv_q[33:32]};
		sq_trial  = {2'b0, root_q, 2'b01};
		sq_fit    = sq_rem_sh >= sq_trial;

		mul_st = (state_q == ST_LK_MUL) || (state_q == ST_OV_MUL) ||
		         (state_q == ST_RP_SQ) || (state_q == ST_RP_FADE) || (state_q == ST_AF);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:       if (in_acc && (op == OP_QUERY)) state_nxt = ST_LK_START;
			ST_LK_START: begin
				if (lk_n == '0)             state_nxt = ST_OV_MUL;
				else if (lk_n == NW'(1))    state_nxt = ST_LK_RD0;
				else                        state_nxt = ST_LK_SCAN;
			end
			ST_LK_SCAN:    if (i_q == lk_last) state_nxt = ST_LK_SCANEND;
			ST_LK_SCANEND: state_nxt = ST_LK_RD0;
			ST_LK_RD0:     state_nxt = ST_LK_RD1;
			ST_LK_RD1:     state_nxt = (lk_n == NW'(1)) ? ST_LK_MUL : ST_LK_RD2;
			ST_LK_RD2:     state_nxt = ST_LK_AMT;
			ST_LK_AMT:     state_nxt = lk_go ? ST_LK_DIV : ST_LK_MUL;
			ST_LK_DIV:     if (div_rsp.done) state_nxt = ST_LK_MUL;
			ST_LK_MUL:     if (mph_q && (step_q == 3'd7)) state_nxt = ST_OV_MUL;
			ST_OV_MUL:     if (mph_q && (step_q == 3'd6)) state_nxt = ST_OV_DIV;
			ST_OV_DIV,
			ST_OV_WAIT: begin
				if (state_q == ST_OV_DIV && al_q != '0) state_nxt = ST_OV_WAIT;
				if (ov_fin) begin
					unique case (phase_q)
						PH_DENS: state_nxt = ST_LK_START;
						PH_GRAD: state_nxt = ST_RP_START;
						PH_RPT:  state_nxt = ST_RP_START;
						PH_RFIN: state_nxt = ST_AF;
					endcase
				end
			end
			ST_RP_START:   state_nxt = (j_q == rn) ? ST_OV_MUL : ST_RP_RD;
			ST_RP_RD:      state_nxt = ST_RP_LD;
			ST_RP_LD:      state_nxt = ST_RP_SQ;
			ST_RP_SQ:      if (mph_q && (step_q == 3'd1)) state_nxt = ST_RP_SQRT;
			ST_RP_SQRT:    if (scnt_q == '0) state_nxt = ST_RP_RATIO;
			ST_RP_RATIO:   state_nxt = rp_sat ? ST_RP_FADE : ST_RP_DIV;
			ST_RP_DIV:     if (div_rsp.done) state_nxt = ST_RP_FADE;
			ST_RP_FADE:    if (mph_q) state_nxt = ST_OV_MUL;
			ST_AF:         if (!uaf_q || mph_q) state_nxt = ST_OUT;
			ST_OUT:        if (out_ok) state_nxt = ST_IDLE;
			default:       state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: memory address, multiplier operands, divider request
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		rd_addr     = '0;
		mul_x       = '0;
		mul_y       = '0;
		div_req     = '0;
		div_num     = '0;
		unique case (state_q)
			ST_LK_SCAN: rd_addr = i_q;
			ST_LK_RD0:  rd_addr = idx_q;
			ST_LK_RD1:  rd_addr = AW'(idx_q + AW'(1));
			ST_RP_RD:   rd_addr = j_q[AW-1:0];
			ST_LK_AMT: begin
				div_req.start = lk_go;
				div_req.den   = lk_ud;
				div_num[0]    = {lk_un, 16'b0};
			end
			ST_RP_RATIO: begin
				div_req.start = !rp_sat;
				div_req.den   = rad_q;
				div_num[0]    = {3'b0, root_q, 12'b0};
			end
			ST_OV_DIV: begin
				div_req.start = (al_q != '0);
				div_req.den   = al_q[15:0];
				div_num       = numacc_q;
			end
			ST_LK_MUL: begin
				if (!step_q[0]) begin
					mul_x = {1'b0, lka_q[step_q[2:1]]};
					mul_y = CH_ONE - amt_q;
				end else begin
					mul_x = {1'b0, lkb_q[step_q[2:1]]};
					mul_y = amt_q;
				end
			end
			ST_OV_MUL: begin
				if (step_q == '0) begin
					mul_x = {1'b0, ovb[3]};
					mul_y = CH_ONE - {1'b0, src_q[3]};
				end else if (step_q[0]) begin
					mul_x = {1'b0, src_q[ov_ch]};
					mul_y = {1'b0, src_q[3]};
				end else begin
					mul_x = {1'b0, ovb[ov_ch]};
					mul_y = {1'b0, t_q};
				end
			end
			ST_RP_SQ: begin
				mul_x = step_q[0] ? {1'b0, dy_q} : {1'b0, dx_q};
				mul_y = mul_x;
			end
			ST_RP_FADE: begin
				mul_x = {1'b0, src_q[3]};
				mul_y = CH_ONE - ratio_q;
			end
			ST_AF: begin
				mul_x = {1'b0, col_q[3]};
				mul_y = {1'b0, af_q};
			end
			default: ;
		endcase
	end

	// point memories, written on transfer, read data registered
	always_ff @(posedge clk) begin
		if (in_acc && slot_ok) begin
			unique case (op)
				OP_DENS:  dmem[AW'(slot)] <= {pos_x, in_alpha, in_blue, in_green, in_red};
				OP_GRAD:  gmem[AW'(slot)] <= {pos_y, in_alpha, in_blue, in_green, in_red};
				OP_RAD:   rmem[AW'(slot)] <= {pos_x, pos_y, radius,
				                              in_alpha, in_blue, in_green, in_red};
				default: ;
			endcase
		end
		dens_rd_q <= dmem[rd_addr];
		grad_rd_q <= gmem[rd_addr];
		rad_rd_q  <= rmem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_DENS;
			step_q      <= '0;
			mph_q       <= 1'b0;
			i_q         <= '0;
			idx_q       <= '0;
			j_q         <= '0;
			lk_sel_q    <= 1'b0;
			ov_acc_q    <= 1'b0;
			scan_vld_s1 <= 1'b0;
			scan_idx_s1 <= '0;
			out_valid_q <= 1'b0;
			dens_cnt_q  <= '0;
			grad_cnt_q  <= '0;
			rad_cnt_q   <= '0;
			af_q        <= AF_RESET;
		end else begin
			state_q <= state_nxt;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DENS_CNT: dens_cnt_q <= cfg_data[CNT_W-1:0];
					REG_GRAD_CNT: grad_cnt_q <= cfg_data[CNT_W-1:0];
					REG_RAD_CNT:  rad_cnt_q  <= cfg_data[CNT_W-1:0];
					REG_ALPHA_F:  af_q       <= cfg_data;
					default: ;
				endcase
			end

			if (in_acc && (op == OP_QUERY)) begin
				phase_q  <= PH_DENS;
				lk_sel_q <= 1'b0;
				ov_acc_q <= 1'b0;
			end

			// key scan: compare the key read in the previous cycle
			scan_vld_s1 <= (state_q == ST_LK_SCAN);
			scan_idx_s1 <= i_q;
			if (state_q == ST_LK_START) begin
				i_q   <= '0;
				idx_q <= '0;
			end else if (state_q == ST_LK_SCAN) begin
				i_q <= i_q + AW'(1);
			end
			if (scan_vld_s1 && (lk_q > rd_lin.key))
				idx_q <= scan_idx_s1;

			if (ov_fin) begin
				unique case (phase_q)
					PH_DENS: begin
						phase_q  <= PH_GRAD;
						lk_sel_q <= 1'b1;
					end
					PH_GRAD: begin
						phase_q  <= PH_RPT;
						j_q      <= '0;
						ov_acc_q <= 1'b1;
					end
					PH_RPT:  j_q <= j_q + NW'(1);
					PH_RFIN: ;
				endcase
			end
			if ((state_q == ST_RP_START) && (j_q == rn)) begin
				phase_q  <= PH_RFIN;
				ov_acc_q <= 1'b0;
			end

			if (state_nxt != state_q) begin
				step_q <= '0;
				mph_q  <= 1'b0;
			end else if (mul_st) begin
				mph_q <= !mph_q;
				if (mph_q)
					step_q <= step_q + 3'd1;
			end

			if ((state_q == ST_OUT) && out_ok)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;

		if (in_acc && (op == OP_QUERY)) begin
			qx_q  <= pos_x;
			qy_q  <= pos_y;
			uaf_q <= use_alpha_factor;
			col_q <= '0;
		end

		if (ov_fin) begin
			if (ov_acc_q)
				acc_q <= ov_res;
			else
				col_q <= ov_res;
			if (phase_q == PH_GRAD)
				acc_q <= '0;
		end

		unique case (state_q)
			ST_LK_START: if (lk_n == '0) src_q <= '0;
			ST_LK_RD1: begin
				lka_q <= rd_lin.col;
				kl_q  <= rd_lin.key;
				if (lk_n == NW'(1)) begin
					lkb_q <= rd_lin.col;
					amt_q <= '0;
				end
			end
			ST_LK_RD2: begin
				lkb_q <= rd_lin.col;
				kr_q  <= rd_lin.key;
			end
			ST_LK_AMT: amt_q <= lk_sat ? CH_ONE : '0;
			ST_LK_DIV: if (div_rsp.done) amt_q <= {1'b0, div_quo[0]};
			ST_LK_MUL: begin
				if (mph_q) begin
					if (!step_q[0])
						sum_q <= prod_q[32:0];
					else
						src_q[step_q[2:1]] <= lk_sum[31:16];
				end
			end
			ST_OV_MUL: begin
				if (mph_q) begin
					if (step_q == '0) begin
						t_q  <= prod_q[31:16];
						al_q <= {1'b0, src_q[3]} + {1'b0, prod_q[31:16]};
					end else if (step_q[0]) begin
						numacc_q[ov_ch] <= prod_q[31:0];
					end else begin
						numacc_q[ov_ch] <= numacc_q[ov_ch] + prod_q[31:0];
					end
				end
			end
			ST_RP_START: if (j_q == rn) src_q <= acc_q;
			ST_RP_LD: begin
				src_q <= rad_rd_q.col;
				rad_q <= rad_rd_q.rad;
				dx_q  <= (qx_q > rad_rd_q.x) ? qx_q - rad_rd_q.x : rad_rd_q.x - qx_q;
				dy_q  <= (qy_q > rad_rd_q.y) ? qy_q - rad_rd_q.y : rad_rd_q.y - qy_q;
			end
			ST_RP_SQ: begin
				if (mph_q) begin
					if (step_q == '0) begin
						sq_q <= prod_q[32:0];
					end else begin
						sqv_q  <= {1'b0, sq_q + prod_q[32:0]};
						root_q <= '0;
						srem_q <= '0;
						scnt_q <= 5'(SQRT_STEPS - 1);
					end
				end
			end
			ST_RP_SQRT: begin
				// one root bit per cycle, two radicand bits consumed
				srem_q <= sq_fit ? 19'(sq_rem_sh - sq_trial) : sq_rem_sh[18:0];
				root_q <= {root_q[15:0], sq_fit};
				sqv_q  <= {sqv_q[31:0], 2'b00};
				scnt_q <= scnt_q - 5'd1;
			end
			ST_RP_RATIO: if (rp_sat) ratio_q <= CH_ONE;
			ST_RP_DIV:   if (div_rsp.done) ratio_q <= {1'b0, div_quo[0]};
			ST_RP_FADE:  if (mph_q) src_q[3] <= prod_q[31:16];
			ST_AF: begin
				if (uaf_q && mph_q)
					col_q[3] <= (af_prod[19:16] != '0) ? CH_MAX : af_prod[15:0];
			end
			ST_OUT: if (out_ok) out_q <= col_q;
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_red   = out_q[0];
	assign out_green = out_q[1];
	assign out_blue  = out_q[2];
	assign out_alpha = out_q[3];

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_ov_wait_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OV_WAIT) |-> (al_q != '0))
		else $error("over divide with zero alpha");

	a_ov_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OV_DIV) |-> (al_q <= {1'b0, CH_MAX}))
		else $error("composited alpha beyond one");

	a_scan_origin: assert property (@(posedge clk) disable iff (!arst_n)
		scan_vld_s1 |-> ($past(state_q) == ST_LK_SCAN))
		else $error("key compare outside scan");

endmodule
